/* design/stq_pkg.sv */
// shared types, sizes and codes for the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HDL_W = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXPIRED   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] duration;
    logic [15:0] handle;
    logic [15:0] target_id;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] timer_number;
    logic [15:0] action_tag;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    idx_inc;
    logic    insert;
    logic    remove;
    logic    bump;
    logic    emit;
    status_t emit_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0]       cmd;
    logic             full;
    logic             empty;
    logic             scan_end;
    logic             add_go;
    logic             id_hit;
    logic             expire_now;
    logic             expire_last;
    logic [OCC_W-1:0] count;
  } dp_stat_t;

endpackage

/* design/stq_datapath.sv */
// timer entries, time and id counters, scan index and result register
`timescale 1ns / 1ps
module stq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  stq_pkg::request_t request,
  input  stq_pkg::dp_cmd_t  cmd,
  output stq_pkg::dp_stat_t stat,
  output stq_pkg::result_t  result,
  output logic              result_valid
);

  logic [31:0]                exp_q [stq_pkg::DEPTH];
  logic [15:0]                id_q  [stq_pkg::DEPTH];
  logic [stq_pkg::HDL_W-1:0]  hdl_q [stq_pkg::DEPTH];

  logic [stq_pkg::OCC_W-1:0]  occ;
  logic [31:0]                now;
  logic [15:0]                next_id;
  logic [stq_pkg::OCC_W-1:0]  idx;
  logic [stq_pkg::CNT_W-1:0]  cnt;
  stq_pkg::request_t          req_q;
  logic [31:0]                new_exp;
  logic [32:0]                exp_sum;
  logic [stq_pkg::IDX_W-1:0]  rd_idx;
  logic [31:0]                exp_second;
  logic [stq_pkg::CNT_W:0]    cnt_plus;
  stq_pkg::result_t           result_next;

  assign exp_sum  = {1'b0, now} + 33'(request.duration);
  assign rd_idx   = (idx == occ) ? '0 : idx[stq_pkg::IDX_W-1:0];
  assign cnt_plus = {1'b0, cnt} + 1'b1;

  generate
    if (stq_pkg::DEPTH > 1) begin : g_second
      assign exp_second = exp_q[1];
    end else begin : g_no_second
      assign exp_second = '0;
    end
  endgenerate

  always_comb begin
    stat.cmd        = req_q.cmd;
    stat.full       = (occ == stq_pkg::OCC_W'(stq_pkg::DEPTH));
    stat.empty      = (occ == '0);
    stat.scan_end   = (idx == occ);
    stat.add_go     = (exp_q[rd_idx] <= new_exp);
    stat.id_hit     = (id_q[rd_idx] == req_q.target_id);
    stat.expire_now = (cnt < stq_pkg::CNT_W'(stq_pkg::MAX_RESULTS)) && (occ != '0) &&
                      (exp_q[0] < now);
    // high when the next head would not go out in this same tick
    stat.expire_last = !((cnt_plus < (stq_pkg::CNT_W + 1)'(stq_pkg::MAX_RESULTS)) &&
                         (occ > stq_pkg::OCC_W'(1)) && (exp_second < now));
    stat.count      = occ;
  end

  always_comb begin
    result_next.status       = cmd.emit_status;
    result_next.timer_number = '0;
    result_next.action_tag   = '0;
    result_next.last         = 1'b1;
    unique case (cmd.emit_status)
      stq_pkg::ST_ADDED:     result_next.timer_number = next_id;
      stq_pkg::ST_FULL:      result_next.timer_number = '0;
      stq_pkg::ST_DELETED:   result_next.timer_number = req_q.target_id;
      stq_pkg::ST_NOT_FOUND: result_next.timer_number = req_q.target_id;
      stq_pkg::ST_EXPIRED: begin
        result_next.timer_number = id_q[0];
        result_next.action_tag   = 16'(hdl_q[0]);
        result_next.last         = stat.expire_last;
      end
      default: result_next.timer_number = '0;
    endcase
  end

  // per-entry shift network: insert opens a slot at idx, remove closes it
  genvar gi;
  generate
    for (gi = 0; gi < stq_pkg::DEPTH; gi++) begin : g_entry
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (idx[stq_pkg::IDX_W-1:0] == stq_pkg::IDX_W'(gi)) begin
            exp_q[gi] <= new_exp;
            id_q[gi]  <= next_id;
            hdl_q[gi] <= req_q.handle[stq_pkg::HDL_W-1:0];
          end else if (idx[stq_pkg::IDX_W-1:0] < stq_pkg::IDX_W'(gi)) begin
            if (gi > 0) begin
              exp_q[gi] <= exp_q[(gi > 0) ? gi - 1 : 0];
              id_q[gi]  <= id_q[(gi > 0) ? gi - 1 : 0];
              hdl_q[gi] <= hdl_q[(gi > 0) ? gi - 1 : 0];
            end
          end
        end else if (cmd.remove) begin
          if (gi < stq_pkg::DEPTH - 1 && idx[stq_pkg::IDX_W-1:0] <= stq_pkg::IDX_W'(gi)) begin
            exp_q[gi] <= exp_q[(gi < stq_pkg::DEPTH - 1) ? gi + 1 : gi];
            id_q[gi]  <= id_q[(gi < stq_pkg::DEPTH - 1) ? gi + 1 : gi];
            hdl_q[gi] <= hdl_q[(gi < stq_pkg::DEPTH - 1) ? gi + 1 : gi];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= request;
      new_exp <= exp_sum[32] ? stq_pkg::TIME_MAX : exp_sum[31:0];
    end
    if (cmd.emit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= '0;
      now          <= '0;
      next_id      <= '0;
      idx          <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.load) begin
        idx <= '0;
        cnt <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.emit) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.bump && now != stq_pkg::TIME_MAX) begin
        now <= now + 1'b1;
      end
      if (cmd.insert) begin
        occ     <= occ + 1'b1;
        next_id <= next_id + 1'b1;
      end else if (cmd.remove) begin
        occ <= occ - 1'b1;
        // queue empties: time and ids restart
        if (occ == stq_pkg::OCC_W'(1)) begin
          now     <= '0;
          next_id <= '0;
        end
      end
    end
  end

endmodule

/* design/stq_ctrl.sv */
// command sequencer for the sorted timer queue
`timescale 1ns / 1ps
module stq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  stq_pkg::dp_stat_t stat,
  output stq_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_ADD_SCAN = 5'b00100,
    S_DEL_SCAN = 5'b01000,
    S_TICK     = 5'b10000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_status = stq_pkg::ST_ADDED;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          stq_pkg::CMD_ADD: begin
            if (stat.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = stq_pkg::ST_FULL;
              state_next      = S_IDLE;
            end else begin
              state_next = S_ADD_SCAN;
            end
          end
          stq_pkg::CMD_DELETE: state_next = S_DEL_SCAN;
          stq_pkg::CMD_TICK: begin
            if (stat.empty) begin
              state_next = S_IDLE;
            end else begin
              cmd.bump   = 1'b1;
              state_next = S_TICK;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ADD_SCAN: begin
        if (!stat.scan_end && stat.add_go) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.insert      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = stq_pkg::ST_ADDED;
          state_next      = S_IDLE;
        end
      end
      S_DEL_SCAN: begin
        priority if (stat.scan_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stq_pkg::ST_NOT_FOUND;
          state_next      = S_IDLE;
        end else if (stat.id_hit) begin
          cmd.remove      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = stq_pkg::ST_DELETED;
          state_next      = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TICK: begin
        // idx stays at zero, so remove pops the head
        if (stat.expire_now) begin
          cmd.remove      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = stq_pkg::ST_EXPIRED;
          if (stat.expire_last) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/sorted_timer_queue.sv */
// top level of the sorted timer queue: controller plus datapath
//
// channel   ports                        transaction
// request   start, busy, request         start && !busy at a rising edge
// result    result_valid, result         result_valid high for one cycle
//
// a command is accepted only while busy is low; the next cycle decodes it.
// add scans past the entries with expiry not later than the new one and inserts
// after them, or answers full without a scan when full. delete scans up to the match,
// or through the whole occupancy when absent. a tick on an empty queue gives no
// result; else it pops expired timers from the head in turn. each result shows for one
// cycle; the receiver cannot stall. synchronous reset empties the queue.
`timescale 1ns / 1ps
module sorted_timer_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  stq_pkg::request_t request,
  output logic              busy,
  output stq_pkg::result_t  result,
  output logic              result_valid
);

  stq_pkg::dp_cmd_t  dp_cmd;
  stq_pkg::dp_stat_t dp_stat;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (dp_stat),
    .cmd   (dp_cmd),
    .busy  (busy)
  );

  stq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .result       (result),
    .result_valid (result_valid)
  );

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    dp_stat.count <= stq_pkg::OCC_W'(stq_pkg::DEPTH))
    else $error("occupancy beyond depth");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != 3'(stq_pkg::ST_EXPIRED) |-> result.last)
    else $error("add or delete transaction without last");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !result_valid)
    else $error("result right after accept");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("idle while expiries still pending");
`endif

endmodule
